// ===== sv/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// Array table engine package
// Shared widths, codes, transaction structs and sequencer states.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACT_W   = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int LO_W    = 6;
	localparam int HI_W    = 7;
	localparam int CAP_W   = 7;
	localparam int FOUND_W = 7;
	localparam int CNT_W   = 7;
	localparam int BS_W    = 8;

	localparam logic [CAP_W-1:0]       CAP_RESET = 7'd64;
	localparam logic signed [BS_W-1:0] BS_ONE    = 8'sd1;

	// Entries in each of the two small queues.
	localparam int QDEPTH = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND  = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_LSEARCH = 3'd3,
		ACT_BSEARCH = 3'd4,
		ACT_READ    = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_INSERT,
		OP_DELETE,
		OP_LSEARCH,
		OP_BSEARCH,
		OP_READ,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_REJECT = 2'd1,
		STAT_MISS   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SHIFT_UP,
		ST_INS_PUT,
		ST_SHIFT_DOWN,
		ST_LS_SCAN,
		ST_LS_PUT0,
		ST_BS_ISSUE,
		ST_BS_CMP,
		ST_RD_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                     op;
		logic [POS_W-1:0]        pos;
		logic [VAL_W-1:0]        value;
		logic [VAL_W-1:0]        key;
		logic signed [BS_W-1:0]  lo;
		logic signed [BS_W-1:0]  hi;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [FOUND_W-1:0]   found_index;
		logic [VAL_W-1:0]     read_data;
		logic [CNT_W-1:0]     entry_count;
	} res_t;

endpackage

// ===== sv/ate_fifo.sv =====
// ----------------------------------------------------------------------------
// Array table engine queue
// Small first-in first-out queue of one transaction type, push/full and
// pop/empty on its two sides.
// ----------------------------------------------------------------------------
module ate_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t wdata,
	input  logic  pop,
	output logic  empty,
	output item_t rdata
);
	import ate_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t          slot_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    fill_q;
	logic           push_ok;
	logic           pop_ok;

	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign full    = (fill_q == (PW+1)'(QDEPTH));
	assign empty   = (fill_q == '0);
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push_ok, pop_ok})
				2'b10:   fill_q <= fill_q + (PW+1)'(1);
				2'b01:   fill_q <= fill_q - (PW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/ate_front.sv =====
// ----------------------------------------------------------------------------
// Array table engine front end
// Accepts request transactions, decodes the action and clamps the binary
// search upper bound, and queues the decoded command for the back end.
// ----------------------------------------------------------------------------
module ate_front #(
	parameter int DEPTH = ate_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [ate_pkg::ACT_W-1:0]        action,
	input  logic [ate_pkg::POS_W-1:0]        position,
	input  logic signed [ate_pkg::VAL_W-1:0] value,
	input  logic signed [ate_pkg::VAL_W-1:0] key,
	input  logic [ate_pkg::LO_W-1:0]         search_low,
	input  logic signed [ate_pkg::HI_W-1:0]  search_high,
	output ate_pkg::cmd_t                    cmd,
	output logic                             cmd_valid,
	input  logic                             cmd_ready
);
	import ate_pkg::*;

	cmd_t                   cmd_in;
	logic signed [BS_W-1:0] hi_ext;
	logic                   cmd_empty;

	always_comb begin
		hi_ext        = BS_W'(search_high);
		cmd_in.pos    = position;
		cmd_in.value  = value;
		cmd_in.key    = key;
		cmd_in.lo     = signed'({2'b00, search_low});
		cmd_in.hi     = hi_ext;
		// The upper bound never reaches past the last table entry.
		if (int'(hi_ext) > DEPTH - 1) begin
			cmd_in.hi = BS_W'(DEPTH - 1);
		end
		case (action)
			ACT_APPEND:  cmd_in.op = OP_APPEND;
			ACT_INSERT:  cmd_in.op = OP_INSERT;
			ACT_DELETE:  cmd_in.op = OP_DELETE;
			ACT_LSEARCH: cmd_in.op = OP_LSEARCH;
			ACT_BSEARCH: cmd_in.op = OP_BSEARCH;
			ACT_READ:    cmd_in.op = OP_READ;
			default:     cmd_in.op = OP_BAD;
		endcase
	end

	ate_fifo #(
		.item_t (cmd_t)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cmd_in),
		.pop    (cmd_ready && cmd_valid),
		.empty  (cmd_empty),
		.rdata  (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/ate_back.sv =====
// ----------------------------------------------------------------------------
// Array table engine back end
// Sequencer that owns the table memory and the entry count and carries out
// one command at a time, then pushes its result transaction.
// ----------------------------------------------------------------------------
module ate_back #(
	parameter int DEPTH      = ate_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ate_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ate_pkg::cmd_t             cmd,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [ate_pkg::CAP_W-1:0] capacity,
	output ate_pkg::res_t             res,
	output logic                      res_push,
	input  logic                      res_full
);
	import ate_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > POS_W) ? CW : POS_W;
	localparam int DW = DATA_WIDTH;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          w_q;
	logic [DW-1:0]          e0_q;
	logic signed [BS_W-1:0] lo_q, hi_q;
	logic [BS_W-2:0]        mid_q;
	status_t                status_q;
	logic [FOUND_W-1:0]     found_q;
	logic [VAL_W-1:0]       rdata_q;

	logic [DW-1:0]          mem [DEPTH];
	logic [DW-1:0]          rd_q;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [DW-1:0]          mem_wdata;

	logic [DW-1:0]          val_n, key_n;
	logic [IW-1:0]          cnt_x, pos_x, cap_x;
	logic                   tbl_full, ins_ok, idx_ok, del_last;
	logic                   su_last, sd_last, ls_hit, ls_last;
	logic signed [BS_W-1:0] bs_sum, mid_s;
	logic [BS_W-2:0]        mid_n;
	logic                   bs_hit, bs_less, bs_miss;
	logic                   take;

	assign val_n    = DW'($signed(cmd_q.value));
	assign key_n    = DW'($signed(cmd_q.key));
	assign cnt_x    = IW'(count_q);
	assign pos_x    = IW'(cmd_q.pos);
	assign cap_x    = IW'(capacity);
	assign tbl_full = (cnt_x >= cap_x) || (count_q >= CW'(DEPTH));
	assign ins_ok   = !tbl_full && (pos_x <= cnt_x);
	assign idx_ok   = (pos_x < cnt_x);
	assign del_last = (pos_x + IW'(1) == cnt_x);
	assign su_last  = (w_q == pos_x + IW'(1));
	assign sd_last  = (w_q + IW'(2) == cnt_x);
	assign ls_hit   = (rd_q == key_n);
	assign ls_last  = (w_q + IW'(1) == cnt_x);
	assign bs_sum   = lo_q + hi_q;
	assign mid_n    = bs_sum[BS_W-1:1];
	assign mid_s    = signed'({1'b0, mid_q});
	assign bs_hit   = (rd_q == key_n);
	assign bs_less  = ($signed(key_n) < $signed(rd_q));
	assign bs_miss  = bs_less ? (lo_q > mid_s - BS_ONE) : (mid_s + BS_ONE > hi_q);

	// Commands are only taken while the result queue has room, so the
	// push at the end of the command never meets a full queue.
	assign cmd_ready = (state_q == ST_IDLE) && !res_full;
	assign take      = cmd_ready && cmd_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (cmd_q.op)
					OP_INSERT: begin
						if (!ins_ok) state_d = ST_FINISH;
						else if (pos_x == cnt_x) state_d = ST_INS_PUT;
						else state_d = ST_SHIFT_UP;
					end
					OP_DELETE: begin
						state_d = (idx_ok && !del_last) ? ST_SHIFT_DOWN : ST_FINISH;
					end
					OP_LSEARCH: begin
						state_d = (count_q != '0) ? ST_LS_SCAN : ST_FINISH;
					end
					OP_BSEARCH: begin
						state_d = (cmd_q.lo <= cmd_q.hi) ? ST_BS_ISSUE : ST_FINISH;
					end
					OP_READ: begin
						state_d = idx_ok ? ST_RD_WAIT : ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_SHIFT_UP: begin
				if (su_last) state_d = ST_INS_PUT;
			end
			ST_INS_PUT:    state_d = ST_FINISH;
			ST_SHIFT_DOWN: begin
				if (sd_last) state_d = ST_FINISH;
			end
			ST_LS_SCAN: begin
				if (ls_hit) state_d = (w_q == '0) ? ST_FINISH : ST_LS_PUT0;
				else if (ls_last) state_d = ST_FINISH;
			end
			ST_LS_PUT0:  state_d = ST_FINISH;
			ST_BS_ISSUE: state_d = ST_BS_CMP;
			ST_BS_CMP: begin
				state_d = (bs_hit || bs_miss) ? ST_FINISH : ST_BS_ISSUE;
			end
			ST_RD_WAIT: state_d = ST_FINISH;
			ST_FINISH:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(w_q);
		mem_wdata = rd_q;
		mem_raddr = AW'(w_q);
		res_push  = 1'b0;
		case (state_q)
			ST_DISPATCH: begin
				case (cmd_q.op)
					OP_APPEND: begin
						mem_we    = !tbl_full;
						mem_waddr = AW'(count_q);
						mem_wdata = val_n;
					end
					OP_INSERT:  mem_raddr = AW'(cnt_x - IW'(1));
					OP_DELETE:  mem_raddr = AW'(pos_x + IW'(1));
					OP_LSEARCH: mem_raddr = '0;
					OP_READ:    mem_raddr = AW'(pos_x);
					default:    mem_raddr = AW'(w_q);
				endcase
			end
			ST_SHIFT_UP: begin
				mem_we    = 1'b1;
				mem_raddr = AW'(w_q - IW'(2));
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = val_n;
			end
			ST_SHIFT_DOWN: begin
				mem_we    = 1'b1;
				mem_raddr = AW'(w_q + IW'(2));
			end
			ST_LS_SCAN: begin
				mem_raddr = AW'(w_q + IW'(1));
				// The match moves to the front: entry 0 goes to its slot first.
				if (ls_hit && (w_q != '0)) begin
					mem_we    = 1'b1;
					mem_wdata = e0_q;
				end
			end
			ST_LS_PUT0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_n;
			end
			ST_BS_ISSUE: mem_raddr = AW'(mid_n);
			ST_FINISH:   res_push = 1'b1;
			default:     mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_DISPATCH: begin
					if (cmd_q.op == OP_APPEND && !tbl_full) begin
						count_q <= count_q + CW'(1);
					end else if (cmd_q.op == OP_DELETE && idx_ok && del_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_INS_PUT: count_q <= count_q + CW'(1);
				ST_SHIFT_DOWN: begin
					if (sd_last) count_q <= count_q - CW'(1);
				end
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) cmd_q <= cmd;
			end
			ST_DISPATCH: begin
				status_q <= STAT_REJECT;
				found_q  <= '1;
				rdata_q  <= '0;
				case (cmd_q.op)
					OP_APPEND: begin
						if (!tbl_full) status_q <= STAT_OK;
					end
					OP_INSERT: begin
						w_q <= (pos_x == cnt_x) ? pos_x : cnt_x;
					end
					OP_DELETE: begin
						w_q <= pos_x;
						if (idx_ok && del_last) status_q <= STAT_OK;
					end
					OP_LSEARCH: begin
						status_q <= STAT_MISS;
						w_q      <= '0;
					end
					OP_BSEARCH: begin
						status_q <= STAT_MISS;
						lo_q     <= cmd_q.lo;
						hi_q     <= cmd_q.hi;
					end
					default: w_q <= w_q;
				endcase
			end
			ST_SHIFT_UP: w_q <= w_q - IW'(1);
			ST_INS_PUT:  status_q <= STAT_OK;
			ST_SHIFT_DOWN: begin
				w_q <= w_q + IW'(1);
				if (sd_last) status_q <= STAT_OK;
			end
			ST_LS_SCAN: begin
				if (w_q == '0) e0_q <= rd_q;
				if (ls_hit) status_q <= STAT_OK;
				else w_q <= w_q + IW'(1);
			end
			ST_BS_ISSUE: mid_q <= mid_n;
			ST_BS_CMP: begin
				if (bs_hit) begin
					status_q <= STAT_OK;
					found_q  <= FOUND_W'(mid_q);
				end else if (bs_less) begin
					hi_q <= mid_s - BS_ONE;
				end else begin
					lo_q <= mid_s + BS_ONE;
				end
			end
			ST_RD_WAIT: begin
				rdata_q  <= VAL_W'($signed(rd_q));
				status_q <= STAT_OK;
			end
			default: w_q <= w_q;
		endcase
	end

	assign res.status      = status_q;
	assign res.found_index = found_q;
	assign res.read_data   = rdata_q;
	assign res.entry_count = CNT_W'(count_q);

	a_push_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after a result");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("table written while no command is active");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)) ||
			(count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !res_full)
		else $error("command taken with no room for its result");

endmodule

// ===== sv/array_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// Array table engine
// Ordered table of signed entries with append, insert, delete, linear
// search, binary search and read requests.
// ----------------------------------------------------------------------------
// Requests enter through a queue interface (push/full) and results leave
// through another (empty/pop); each request yields exactly one result. The
// capacity register is written over cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high. The user must write the capacity register only while no
// request is in flight; the block itself does not enforce this. Requests
// are carried out one at a time by the back-end sequencer, which owns a
// single-port-write, registered-read table memory. Insert and delete shift
// entries and linear search scans them, one memory access per entry moved
// or scanned; binary search makes at most 7 probes for 64 entries. A
// two-entry queue on each side lets requests pile up while a long one runs
// and lets results wait while the receiver holds pop low. Reset clears the
// count and sets capacity to 64; table contents are undefined until written.
// ----------------------------------------------------------------------------
module array_table_engine_top #(
	parameter int DEPTH      = ate_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ate_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [ate_pkg::ACT_W-1:0]          action,
	input  logic [ate_pkg::POS_W-1:0]          position,
	input  logic signed [ate_pkg::VAL_W-1:0]   value,
	input  logic signed [ate_pkg::VAL_W-1:0]   key,
	input  logic [ate_pkg::LO_W-1:0]           search_low,
	input  logic signed [ate_pkg::HI_W-1:0]    search_high,
	output logic                               empty,
	input  logic                               pop,
	output logic [1:0]                         status,
	output logic signed [ate_pkg::FOUND_W-1:0] found_index,
	output logic signed [ate_pkg::VAL_W-1:0]   read_data,
	output logic [ate_pkg::CNT_W-1:0]          entry_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ate_pkg::CAP_W-1:0]          cfg_data
);
	import ate_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	cmd_t             cmd;
	logic             cmd_valid, cmd_ready;
	res_t             res_in, res_out;
	logic             res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	ate_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.position    (position),
		.value       (value),
		.key         (key),
		.search_low  (search_low),
		.search_high (search_high),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready)
	);

	ate_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.capacity  (capacity_q),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	ate_fifo #(
		.item_t (res_t)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign status      = res_out.status;
	assign found_index = signed'(res_out.found_index);
	assign read_data   = signed'(res_out.read_data);
	assign entry_count = res_out.entry_count;

endmodule
